// File: src/otwpc_pkg.sv
// Package for the three-wheel omni P controller core.
// Holds field widths, register codes, scaling reciprocals and the fixed-point
// coefficients. No dependencies.
`default_nettype none

package otwpc_pkg;

    localparam int COUNT_W   = 24;
    localparam int OUT_W     = 24;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int TGT_XY_W  = 16;
    localparam int TGT_H_W   = 10;
    localparam int GAIN_W    = 8;
    localparam int Q_FRAC    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_X       = 3'd0,
        CFG_TARGET_Y       = 3'd1,
        CFG_TARGET_HEADING = 3'd2,
        CFG_GAIN_X         = 3'd3,
        CFG_GAIN_Y         = 3'd4,
        CFG_GAIN_HEADING   = 3'd5
    } t_cfg_idx;

    localparam logic [GAIN_W-1:0] GAIN_X_RST = 8'd3;
    localparam logic [GAIN_W-1:0] GAIN_Y_RST = 8'd3;
    localparam logic [GAIN_W-1:0] GAIN_H_RST = 8'd10;

    // Full-scale encoder counts for each pose axis
    localparam longint X_FULL_COUNTS       = 392;
    localparam longint Y_FULL_COUNTS       = 375;
    localparam longint HEADING_FULL_COUNTS = 3407;

    localparam int NUM_AXES = 3;
    localparam int AXIS_X   = 0;
    localparam int AXIS_Y   = 1;
    localparam int AXIS_H   = 2;

    // Magnitude of the combined wheel counts per axis, and its signed form
    localparam int MAG_W = 26;
    localparam int SUM1_W = MAG_W + 1;

    // Pose = SCALE * combined count / FULL_COUNTS, SCALE folds the Q16
    // kinematic coefficient together with 30 or 360
    localparam longint SCALE_X = 30 * 32768;
    localparam longint SCALE_Y = 30 * 56754;
    localparam longint SCALE_H = 360 * 32768;

    localparam longint RECIP_X = (SCALE_X << MAG_W) / X_FULL_COUNTS;
    localparam longint RECIP_Y = (SCALE_Y << MAG_W) / Y_FULL_COUNTS;
    localparam longint RECIP_H = (SCALE_H << MAG_W) / HEADING_FULL_COUNTS;
    localparam longint RECIP_XY_MAX = (RECIP_X > RECIP_Y) ? RECIP_X : RECIP_Y;
    localparam longint RECIP_MAX = (RECIP_XY_MAX > RECIP_H) ? RECIP_XY_MAX : RECIP_H;
    localparam longint FULL_XY_MAX =
        (X_FULL_COUNTS > Y_FULL_COUNTS) ? X_FULL_COUNTS : Y_FULL_COUNTS;
    localparam longint FULL_MAX =
        (FULL_XY_MAX > HEADING_FULL_COUNTS) ? FULL_XY_MAX : HEADING_FULL_COUNTS;

    localparam int QUO_W      = $clog2(RECIP_MAX + 1);
    localparam int REM_W      = $clog2(FULL_MAX) + 1;
    localparam int RECIP_LO_W = 20;
    localparam int RECIP_HI_W = QUO_W - RECIP_LO_W;
    localparam int PLO_W      = MAG_W + RECIP_LO_W;
    localparam int PHI_W      = MAG_W + RECIP_HI_W;
    localparam int FP_W       = MAG_W + QUO_W;

    localparam logic [QUO_W-1:0] RECIP [NUM_AXES] =
        '{QUO_W'(RECIP_X), QUO_W'(RECIP_Y), QUO_W'(RECIP_H)};
    localparam logic [REM_W-1:0] SCALE_LO [NUM_AXES] =
        '{REM_W'(SCALE_X), REM_W'(SCALE_Y), REM_W'(SCALE_H)};
    localparam logic [REM_W-1:0] FULL_LO [NUM_AXES] =
        '{REM_W'(X_FULL_COUNTS), REM_W'(Y_FULL_COUNTS), REM_W'(HEADING_FULL_COUNTS)};

    localparam logic [QUO_W-1:0] HEADING_WRAP = QUO_W'(360 * 65536);

    // Error, drive and wheel sum widths
    localparam int ERR_W   = QUO_W + 2;
    localparam int PROD_W  = ERR_W + GAIN_W + 1;
    localparam longint DRIVE_LIMIT = 400 * 65536;
    localparam int DRV_W   = $clog2(DRIVE_LIMIT + 1) + 1;
    localparam longint HEADING_ERR_MAX = ((2 ** (TGT_H_W - 1)) + 360) * 65536;
    localparam int HDRV_W  = $clog2(HEADING_ERR_MAX * 255 + 1) + 1;

    localparam int COEF_W = 17;
    localparam logic signed [COEF_W-1:0] COEF_0333  = COEF_W'(21823);
    localparam logic signed [COEF_W-1:0] COEF_05774 = COEF_W'(37840);
    localparam logic signed [COEF_W-1:0] COEF_0045  = COEF_W'(2949);
    localparam logic signed [COEF_W-1:0] COEF_0667  = COEF_W'(43713);

    localparam int PXY_W = DRV_W + COEF_W;
    localparam int PH_W  = HDRV_W + COEF_W;
    localparam int SUM_W = PH_W + 2;

    // Q32 to Q8
    localparam int ROUND_SHIFT = 24;
    localparam int SH_W        = SUM_W - ROUND_SHIFT;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'sd1 << (ROUND_SHIFT - 1));
    localparam logic signed [SH_W-1:0] OUT_HI = SH_W'((64'sd1 << (OUT_W - 1)) - 1);
    localparam logic signed [SH_W-1:0] OUT_LO = SH_W'(-(64'sd1 << (OUT_W - 1)));

    localparam int NSTG = 10;

endpackage

`default_nettype wire

// File: src/omni_three_wheel_p_controller_core.sv
// Three-wheel omni robot core: encoder counts to wheel speed commands through
// forward kinematics, P control and inverse kinematics. Uses otwpc_pkg.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+--------------------------------------
//   counts   | in        | i_valid / o_stall     | i_count_a, i_count_b, i_count_c
//   speeds   | out       | o_valid / i_stall     | o_wheel_one/two/three_speed
//   config   | in        | i_cfg_we (no wait)    | i_cfg_idx, i_cfg_data
//
// Ten register stages; requests come out in order, one per cycle unless i_stall holds the pipe.
// The stage count is set by the reciprocal scaling multiply (split in two partial
// products), the gain multiply and the wheel coefficient multiply.
// Each stage holds only while full and blocked downstream, so bubbles close up.
// Synchronous active-low reset clears the valid bits and the targets, and loads the gain reset values.
`default_nettype none

module omni_three_wheel_p_controller_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [otwpc_pkg::COUNT_W-1:0]  i_count_a,
    input  logic signed [otwpc_pkg::COUNT_W-1:0]  i_count_b,
    input  logic signed [otwpc_pkg::COUNT_W-1:0]  i_count_c,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [otwpc_pkg::OUT_W-1:0]    o_wheel_one_speed,
    output logic signed [otwpc_pkg::OUT_W-1:0]    o_wheel_two_speed,
    output logic signed [otwpc_pkg::OUT_W-1:0]    o_wheel_three_speed,
    input  logic                                  i_cfg_we,
    input  logic [otwpc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [otwpc_pkg::CFG_W-1:0]           i_cfg_data
);

    import otwpc_pkg::*;

    // ---------------- configuration ----------------
    logic signed [TGT_XY_W-1:0] r_tgt_x;
    logic signed [TGT_XY_W-1:0] r_tgt_y;
    logic signed [TGT_H_W-1:0]  r_tgt_h;
    logic [GAIN_W-1:0]          r_gain_x;
    logic [GAIN_W-1:0]          r_gain_y;
    logic [GAIN_W-1:0]          r_gain_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_x  <= '0;
            r_tgt_y  <= '0;
            r_tgt_h  <= '0;
            r_gain_x <= GAIN_X_RST;
            r_gain_y <= GAIN_Y_RST;
            r_gain_h <= GAIN_H_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TARGET_X:       r_tgt_x  <= $signed(i_cfg_data[TGT_XY_W-1:0]);
                CFG_TARGET_Y:       r_tgt_y  <= $signed(i_cfg_data[TGT_XY_W-1:0]);
                CFG_TARGET_HEADING: r_tgt_h  <= $signed(i_cfg_data[TGT_H_W-1:0]);
                CFG_GAIN_X:         r_gain_x <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_Y:         r_gain_y <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_HEADING:   r_gain_h <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] adv;

    always_comb begin
        adv[NSTG-1] = !r_v[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_stall = !adv[0];
    assign o_valid = r_v[NSTG-1];

    // ---------------- stage 1: kinematic sums, sign and magnitude ----------------
    logic signed [SUM1_W-1:0] ext_a, ext_b, ext_c;
    logic signed [SUM1_W-1:0] sum1 [NUM_AXES];
    logic [MAG_W-1:0]         r_mag1 [NUM_AXES];
    logic                     r_neg1 [NUM_AXES];

    always_comb begin
        ext_a = SUM1_W'(i_count_a);
        ext_b = SUM1_W'(i_count_b);
        ext_c = SUM1_W'(i_count_c);
        sum1[AXIS_X] = (ext_c <<< 1) - ext_a - ext_b;
        sum1[AXIS_Y] = ext_a - ext_b;
        sum1[AXIS_H] = (ext_a <<< 1) + (ext_b <<< 1) + (ext_c <<< 1) + ext_c;
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            for (int l = 0; l < NUM_AXES; l++) begin
                r_neg1[l] <= sum1[l][SUM1_W-1];
                r_mag1[l] <= sum1[l][SUM1_W-1] ? MAG_W'(-sum1[l]) : MAG_W'(sum1[l]);
            end
        end
    end

    // ---------------- stage 2: reciprocal partial products ----------------
    logic [PLO_W-1:0]   r_plo2 [NUM_AXES];
    logic [PHI_W-1:0]   r_phi2 [NUM_AXES];
    logic [REM_W-1:0]   r_klo2 [NUM_AXES];
    logic               r_neg2 [NUM_AXES];
    logic [2*REM_W-1:0] klo_full [NUM_AXES];

    always_comb begin
        for (int l = 0; l < NUM_AXES; l++) begin
            klo_full[l] = (2*REM_W)'(SCALE_LO[l]) * (2*REM_W)'(r_mag1[l][REM_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            for (int l = 0; l < NUM_AXES; l++) begin
                r_plo2[l] <= PLO_W'(r_mag1[l]) * PLO_W'(RECIP[l][RECIP_LO_W-1:0]);
                r_phi2[l] <= PHI_W'(r_mag1[l]) * PHI_W'(RECIP[l][QUO_W-1:RECIP_LO_W]);
                r_klo2[l] <= klo_full[l][REM_W-1:0];
                r_neg2[l] <= r_neg1[l];
            end
        end
    end

    // ---------------- stage 3: quotient estimate ----------------
    logic [FP_W-1:0]  prod3 [NUM_AXES];
    logic [QUO_W-1:0] r_q3 [NUM_AXES];
    logic [REM_W-1:0] r_klo3 [NUM_AXES];
    logic             r_neg3 [NUM_AXES];

    always_comb begin
        for (int l = 0; l < NUM_AXES; l++) begin
            prod3[l] = FP_W'(r_plo2[l]) + (FP_W'(r_phi2[l]) << RECIP_LO_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            for (int l = 0; l < NUM_AXES; l++) begin
                r_q3[l]   <= prod3[l][FP_W-1:MAG_W];
                r_klo3[l] <= r_klo2[l];
                r_neg3[l] <= r_neg2[l];
            end
        end
    end

    // ---------------- stage 4: correct the estimate by one ----------------
    // Only the low remainder bits matter: the true remainder is below twice the divisor.
    logic [2*REM_W-1:0] qd4 [NUM_AXES];
    logic [REM_W-1:0]   rem4 [NUM_AXES];
    logic [QUO_W-1:0]   r_q4 [NUM_AXES];
    logic               r_neg4 [NUM_AXES];

    always_comb begin
        for (int l = 0; l < NUM_AXES; l++) begin
            qd4[l]  = (2*REM_W)'(r_q3[l][REM_W-1:0]) * (2*REM_W)'(FULL_LO[l]);
            rem4[l] = r_klo3[l] - qd4[l][REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            for (int l = 0; l < NUM_AXES; l++) begin
                r_q4[l]   <= (rem4[l] >= FULL_LO[l]) ? r_q3[l] + QUO_W'(1) : r_q3[l];
                r_neg4[l] <= r_neg3[l];
            end
        end
    end

    // ---------------- stage 5: heading wrap and error ----------------
    logic signed [ERR_W-1:0] tgt5 [NUM_AXES];
    logic signed [ERR_W-1:0] th_ext;
    logic signed [ERR_W-1:0] pose_mag5 [NUM_AXES];
    logic signed [ERR_W-1:0] r_err5 [NUM_AXES];

    always_comb begin
        th_ext       = ERR_W'($signed({r_tgt_h, {Q_FRAC{1'b0}}}));
        tgt5[AXIS_X] = ERR_W'($signed({r_tgt_x, {Q_FRAC{1'b0}}}));
        tgt5[AXIS_Y] = ERR_W'($signed({r_tgt_y, {Q_FRAC{1'b0}}}));
        tgt5[AXIS_H] = -th_ext;
        for (int l = 0; l < NUM_AXES; l++) begin
            pose_mag5[l] = $signed({2'b00, r_q4[l]});
        end
        // drop a heading at or beyond a full turn
        if (r_q4[AXIS_H] >= HEADING_WRAP) begin
            pose_mag5[AXIS_H] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            for (int l = 0; l < NUM_AXES; l++) begin
                r_err5[l] <= r_neg4[l] ? tgt5[l] + pose_mag5[l] : tgt5[l] - pose_mag5[l];
            end
        end
    end

    // ---------------- stage 6: proportional gain ----------------
    logic signed [GAIN_W:0]   gain6 [NUM_AXES];
    logic signed [PROD_W-1:0] r_drv6 [NUM_AXES];

    always_comb begin
        gain6[AXIS_X] = $signed({1'b0, r_gain_x});
        gain6[AXIS_Y] = $signed({1'b0, r_gain_y});
        gain6[AXIS_H] = $signed({1'b0, r_gain_h});
    end

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            for (int l = 0; l < NUM_AXES; l++) begin
                r_drv6[l] <= PROD_W'(r_err5[l]) * PROD_W'(gain6[l]);
            end
        end
    end

    // ---------------- stage 7: drive clamp (x and y only) ----------------
    localparam logic signed [PROD_W-1:0] LIM_HI = PROD_W'(DRIVE_LIMIT);
    localparam logic signed [PROD_W-1:0] LIM_LO = PROD_W'(-DRIVE_LIMIT);

    logic signed [DRV_W-1:0]  r_dx7;
    logic signed [DRV_W-1:0]  r_dy7;
    logic signed [HDRV_W-1:0] r_dh7;

    function automatic logic signed [DRV_W-1:0] clamp_drive(
        input logic signed [PROD_W-1:0] v
    );
        logic signed [DRV_W-1:0] res;
        if (v > LIM_HI) begin
            res = DRV_W'(LIM_HI);
        end else if (v < LIM_LO) begin
            res = DRV_W'(LIM_LO);
        end else begin
            res = DRV_W'(v);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_dx7 <= clamp_drive(r_drv6[AXIS_X]);
            r_dy7 <= clamp_drive(r_drv6[AXIS_Y]);
            r_dh7 <= HDRV_W'(r_drv6[AXIS_H]);
        end
    end

    // ---------------- stage 8: wheel coefficient products ----------------
    logic signed [PXY_W-1:0] r_px1_8;
    logic signed [PXY_W-1:0] r_py_8;
    logic signed [PXY_W-1:0] r_px3_8;
    logic signed [PH_W-1:0]  r_ph_8;

    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r_px1_8 <= PXY_W'(r_dx7) * PXY_W'(COEF_0333);
            r_py_8  <= PXY_W'(r_dy7) * PXY_W'(COEF_05774);
            r_px3_8 <= PXY_W'(r_dx7) * PXY_W'(COEF_0667);
            r_ph_8  <= PH_W'(r_dh7) * PH_W'(COEF_0045);
        end
    end

    // ---------------- stage 9: wheel sums ----------------
    logic signed [SUM_W-1:0] ex_px1, ex_py, ex_px3, ex_ph;
    logic signed [SUM_W-1:0] r_w9 [NUM_AXES];

    always_comb begin
        ex_px1 = SUM_W'(r_px1_8);
        ex_py  = SUM_W'(r_py_8);
        ex_px3 = SUM_W'(r_px3_8);
        ex_ph  = SUM_W'(r_ph_8);
    end

    always_ff @(posedge i_clk) begin
        if (adv[8]) begin
            r_w9[0] <= ex_ph - ex_px1 + ex_py;
            r_w9[1] <= ex_ph - ex_px1 - ex_py;
            r_w9[2] <= ex_ph + ex_px3;
        end
    end

    // ---------------- stage 10: round to Q8, saturate ----------------
    logic signed [SUM_W-1:0] rnd10 [NUM_AXES];
    logic signed [SH_W-1:0]  sh10 [NUM_AXES];
    logic signed [OUT_W-1:0] r_out [NUM_AXES];

    always_comb begin
        for (int l = 0; l < NUM_AXES; l++) begin
            rnd10[l] = r_w9[l] + ROUND_HALF;
            sh10[l]  = $signed(rnd10[l][SUM_W-1:ROUND_SHIFT]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[9]) begin
            for (int l = 0; l < NUM_AXES; l++) begin
                if (sh10[l] > OUT_HI) begin
                    r_out[l] <= OUT_W'(OUT_HI);
                end else if (sh10[l] < OUT_LO) begin
                    r_out[l] <= OUT_W'(OUT_LO);
                end else begin
                    r_out[l] <= OUT_W'(sh10[l]);
                end
            end
        end
    end

    assign o_wheel_one_speed   = r_out[0];
    assign o_wheel_two_speed   = r_out[1];
    assign o_wheel_three_speed = r_out[2];

    // ---------------- assertions ----------------
    // input backs up only when every stage is full and the output is blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_v) && i_stall))
        else $error("input stalled with room in the pipeline");

    // reciprocal estimate is never short by more than one
    a_rem_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> ((rem4[AXIS_X] < FULL_LO[AXIS_X]) ||
                    ((rem4[AXIS_X] - FULL_LO[AXIS_X]) < FULL_LO[AXIS_X])))
        else $error("x quotient estimate off by more than one");

    a_rem_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> ((rem4[AXIS_Y] < FULL_LO[AXIS_Y]) ||
                    ((rem4[AXIS_Y] - FULL_LO[AXIS_Y]) < FULL_LO[AXIS_Y])))
        else $error("y quotient estimate off by more than one");

    a_rem_h: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> ((rem4[AXIS_H] < FULL_LO[AXIS_H]) ||
                    ((rem4[AXIS_H] - FULL_LO[AXIS_H]) < FULL_LO[AXIS_H])))
        else $error("heading quotient estimate off by more than one");

    // clamped drives stay inside the drive limit
    a_drive_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[6] |-> ((PROD_W'(r_dx7) <= LIM_HI) && (PROD_W'(r_dx7) >= LIM_LO) &&
                    (PROD_W'(r_dy7) <= LIM_HI) && (PROD_W'(r_dy7) >= LIM_LO)))
        else $error("x or y drive outside limit");

    // a finished request reaches the output unless the output is blocked
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NSTG-2] && !(o_valid && i_stall)) |=> o_valid)
        else $error("request lost before the output register");

endmodule

`default_nettype wire

// File: test/omni_three_wheel_p_controller_core_tb.sv
// Self-checking testbench for omni_three_wheel_p_controller_core: encoder counts
// in, wheel speed commands out, checked against a fixed-point pose/P-control predictor.
// Depends on otwpc_pkg and the core RTL only.

module omni_three_wheel_p_controller_core_tb;
    import otwpc_pkg::*;

    // Q16 kinematic and controller coefficients
    localparam longint Q_ONE          = 65536;
    localparam longint K_HALF         = 32768;
    localparam longint K_COS30        = 56754;
    localparam longint K_THREE_HALVES = 98304;
    localparam longint K_THIRD        = 21823;
    localparam longint K_INV_SQRT3    = 37840;
    localparam longint K_SPIN         = 2949;
    localparam longint K_TWO_THIRDS   = 43713;
    localparam longint DRIVE_CAP_Q    = 400 * 65536;
    localparam longint HDG_WRAP_Q     = 360 * 65536;
    localparam longint ROUND_Q8       = 64'sd1 << 23;
    localparam longint SPEED_MAX      = 8388607;
    localparam longint SPEED_MIN      = -8388608;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic signed [COUNT_W-1:0] CNT_MAX = 24'sh7FFFFF;
    localparam logic signed [COUNT_W-1:0] CNT_MIN = 24'sh800000;

    localparam int NUM_PHASES     = 11;
    localparam int ITEMS_PER_PASS = 130;
    localparam int TAIL_CYCLES    = 20;
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic signed [OUT_W-1:0] one;
        logic signed [OUT_W-1:0] two;
        logic signed [OUT_W-1:0] three;
    } t_speeds;

    typedef struct packed {
        logic signed [COUNT_W-1:0] a;
        logic signed [COUNT_W-1:0] b;
        logic signed [COUNT_W-1:0] c;
        bit                        typed;
        t_speeds                   want;
    } t_count_row;

    localparam t_speeds SPEEDS_ZERO = '0;
    localparam int DIR_ROWS = 19;

    // Opening rows; only the all-zero request under reset settings is typed in
    t_count_row dir_rows [DIR_ROWS] = '{
        '{24'sd0,     24'sd0,     24'sd0,    1'b1, SPEEDS_ZERO},
        '{CNT_MAX,    CNT_MAX,    CNT_MAX,   1'b0, SPEEDS_ZERO},
        '{CNT_MIN,    CNT_MIN,    CNT_MIN,   1'b0, SPEEDS_ZERO},
        '{CNT_MAX,    CNT_MIN,    24'sd0,    1'b0, SPEEDS_ZERO},
        '{CNT_MIN,    CNT_MAX,    24'sd0,    1'b0, SPEEDS_ZERO},
        '{24'sd0,     24'sd0,     CNT_MAX,   1'b0, SPEEDS_ZERO},
        '{24'sd0,     24'sd0,     CNT_MIN,   1'b0, SPEEDS_ZERO},
        '{CNT_MAX,    24'sd0,     CNT_MIN,   1'b0, SPEEDS_ZERO},
        '{24'sd3407,  24'sd0,     24'sd0,    1'b0, SPEEDS_ZERO},
        '{24'sd3406,  24'sd0,     24'sd0,    1'b0, SPEEDS_ZERO},
        '{-24'sd3407, 24'sd0,     24'sd0,    1'b0, SPEEDS_ZERO},
        '{-24'sd3406, 24'sd0,     24'sd0,    1'b0, SPEEDS_ZERO},
        '{24'sd0,     24'sd0,     24'sd2272, 1'b0, SPEEDS_ZERO},
        '{24'sd0,     24'sd0,     24'sd2271, 1'b0, SPEEDS_ZERO},
        '{24'sd0,     24'sd0,    -24'sd2272, 1'b0, SPEEDS_ZERO},
        '{24'sd1,     24'sd0,     24'sd0,    1'b0, SPEEDS_ZERO},
        '{-24'sd1,   -24'sd1,    -24'sd1,    1'b0, SPEEDS_ZERO},
        '{24'sd1000, -24'sd1000,  24'sd500,  1'b0, SPEEDS_ZERO},
        '{-24'sd200,  24'sd300,  -24'sd700,  1'b0, SPEEDS_ZERO}
    };

    logic                        i_clk;
    logic                        i_rst_n   = 1'b0;
    logic                        i_valid   = 1'b0;
    logic                        o_stall;
    logic signed [COUNT_W-1:0]   i_count_a = '0;
    logic signed [COUNT_W-1:0]   i_count_b = '0;
    logic signed [COUNT_W-1:0]   i_count_c = '0;
    logic                        o_valid;
    logic                        i_stall   = 1'b0;
    logic signed [OUT_W-1:0]     o_wheel_one_speed;
    logic signed [OUT_W-1:0]     o_wheel_two_speed;
    logic signed [OUT_W-1:0]     o_wheel_three_speed;
    logic                        i_cfg_we  = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_idx = '0;
    logic [CFG_W-1:0]            i_cfg_data = '0;

    // Controller settings as the core should hold them
    longint tgt_x = 0;
    longint tgt_y = 0;
    longint tgt_hdg = 0;
    longint k_x = 3;
    longint k_y = 3;
    longint k_hdg = 10;

    t_speeds speeds_due [$];
    int      mismatches = 0;
    int      cycles_run = 0;
    int      stall_left = 0;
    bit      idle_on = 1'b1;

    omni_three_wheel_p_controller_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_count_a           (i_count_a),
        .i_count_b           (i_count_b),
        .i_count_c           (i_count_c),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_wheel_one_speed   (o_wheel_one_speed),
        .o_wheel_two_speed   (o_wheel_two_speed),
        .o_wheel_three_speed (o_wheel_three_speed),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles_run++;
        if (cycles_run >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint clamp_drive(input longint v);
        if (v > DRIVE_CAP_Q)
            return DRIVE_CAP_Q;
        if (v < -DRIVE_CAP_Q)
            return -DRIVE_CAP_Q;
        return v;
    endfunction

    // Q32 wheel sum to Q8, nearest with ties up, then saturate
    function automatic logic signed [OUT_W-1:0] to_speed(input longint w);
        longint q;
        q = (w + ROUND_Q8) >>> 24;
        if (q > SPEED_MAX)
            q = SPEED_MAX;
        if (q < SPEED_MIN)
            q = SPEED_MIN;
        return q[OUT_W-1:0];
    endfunction

    function automatic t_speeds predict_speeds(input logic signed [COUNT_W-1:0] a, b, c);
        longint ca, cb, cc, px, py, ph, pose_x, pose_y, pose_h;
        longint drv_x, drv_y, drv_h;
        t_speeds s;
        ca = longint'(a);
        cb = longint'(b);
        cc = longint'(c);
        px = -K_HALF * ca - K_HALF * cb + Q_ONE * cc;
        py = K_COS30 * (ca - cb);
        ph = Q_ONE * (ca + cb) + K_THREE_HALVES * cc;
        pose_x = (30 * px) / X_FULL_COUNTS;
        pose_y = (30 * py) / Y_FULL_COUNTS;
        pose_h = (360 * ph) / HEADING_FULL_COUNTS;
        // a full turn or more reads as zero heading
        if (pose_h >= HDG_WRAP_Q || pose_h <= -HDG_WRAP_Q)
            pose_h = 0;
        drv_x = clamp_drive(k_x * (tgt_x * Q_ONE - pose_x));
        drv_y = clamp_drive(k_y * (tgt_y * Q_ONE - pose_y));
        drv_h = k_hdg * (-tgt_hdg * Q_ONE - pose_h);
        s.one   = to_speed(-K_THIRD * drv_x + K_INV_SQRT3 * drv_y + K_SPIN * drv_h);
        s.two   = to_speed(-K_THIRD * drv_x - K_INV_SQRT3 * drv_y + K_SPIN * drv_h);
        s.three = to_speed(K_TWO_THIRDS * drv_x + K_SPIN * drv_h);
        return s;
    endfunction

    // Drive one register write; caller drops the write enable after the batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        logic signed [TGT_XY_W-1:0] xy;
        logic signed [TGT_H_W-1:0]  hdg;
        xy  = data[TGT_XY_W-1:0];
        hdg = data[TGT_H_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_TARGET_X:       tgt_x = longint'(xy);
            CFG_TARGET_Y:       tgt_y = longint'(xy);
            CFG_TARGET_HEADING: tgt_hdg = longint'(hdg);
            CFG_GAIN_X:         k_x = longint'(data[GAIN_W-1:0]);
            CFG_GAIN_Y:         k_y = longint'(data[GAIN_W-1:0]);
            CFG_GAIN_HEADING:   k_hdg = longint'(data[GAIN_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] tx, ty, th, gx, gy, gh);
        write_reg(CFG_TARGET_X, tx);
        write_reg(CFG_TARGET_Y, ty);
        write_reg(CFG_TARGET_HEADING, th);
        write_reg(CFG_GAIN_X, gx);
        write_reg(CFG_GAIN_Y, gy);
        write_reg(CFG_GAIN_HEADING, gh);
        // unused indexes must leave the settings alone
        write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_W'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_counts(input logic signed [COUNT_W-1:0] a, b, c,
                               input bit typed, input t_speeds want);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_count_a <= a;
        i_count_b <= b;
        i_count_c <= c;
        do @(posedge i_clk); while (o_stall);
        speeds_due.push_back(typed ? want : predict_speeds(a, b, c));
    endtask

    function automatic logic signed [COUNT_W-1:0] rand_small(input int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span;
        return COUNT_W'(v);
    endfunction

    function automatic logic signed [COUNT_W-1:0] rand_extreme();
        case ($urandom_range(0, 4))
            0: return CNT_MAX;
            1: return CNT_MIN;
            2: return 24'sd1;
            3: return -24'sd1;
            default: return 24'sd0;
        endcase
    endfunction

    task automatic send_random(input int count);
        logic signed [COUNT_W-1:0] a, b, c;
        int side, sel;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 39) == 0)
                idle_on = ~idle_on;
            sel = $urandom_range(0, 9);
            if (sel < 3) begin
                a = COUNT_W'($urandom);
                b = COUNT_W'($urandom);
                c = COUNT_W'($urandom);
            end else if (sel < 8) begin
                // small moves keep drives partly unclamped; heading can still wrap
                a = rand_small(1500);
                b = rand_small(1500);
                c = rand_small(1500);
            end else if (sel == 8) begin
                // land near a full turn of heading
                side = $urandom_range(0, 1) ? 3407 : -3407;
                c = COUNT_W'(2 * (int'($urandom_range(0, 400)) - 200));
                b = rand_small(800);
                a = COUNT_W'(side - int'(b) - (3 * int'(c)) / 2 + int'($urandom_range(0, 4)) - 2);
            end else begin
                a = rand_extreme();
                b = rand_extreme();
                c = rand_extreme();
            end
            send_counts(a, b, c, 1'b0, SPEEDS_ZERO);
        end
    endtask

    // Drop the request line and drain the pipe before touching settings
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (speeds_due.size() != 0)
            @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_stall <= (stall_left > 0);
        if (stall_left > 0)
            stall_left--;
    end

    always @(posedge i_clk) begin : check_speeds
        t_speeds exp_s;
        if (i_rst_n && o_valid && !i_stall) begin
            stall_left = idle_on ? $urandom_range(0, 7) : 0;
            if (speeds_due.size() == 0) begin
                $error("wheel speeds out with no request pending");
                mismatches++;
            end else begin
                exp_s = speeds_due.pop_front();
                if (o_wheel_one_speed !== exp_s.one) begin
                    $error("wheel_one_speed: expected %0d, got %0d",
                           exp_s.one, o_wheel_one_speed);
                    mismatches++;
                end
                if (o_wheel_two_speed !== exp_s.two) begin
                    $error("wheel_two_speed: expected %0d, got %0d",
                           exp_s.two, o_wheel_two_speed);
                    mismatches++;
                end
                if (o_wheel_three_speed !== exp_s.three) begin
                    $error("wheel_three_speed: expected %0d, got %0d",
                           exp_s.three, o_wheel_three_speed);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_counts(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c,
                        dir_rows[i].typed, dir_rows[i].want);
        send_random(100);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: load_settings(16'h7FFF, 16'h7FFF, 16'd360, 16'd255, 16'd255, 16'd255);
                1: load_settings(16'h8000, 16'h8000, 16'h03FF & 16'(-360),
                                 16'd255, 16'd255, 16'd255);
                2: load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                // junk above each register's width; heading at both 10-bit ends
                3: load_settings(16'h0010, 16'hFFF0, 16'hFDFF, 16'hAB01, 16'h5502, 16'hFF80);
                4: load_settings(16'hFFFF, 16'h0001, 16'h0200, 16'h00FF, 16'h0000, 16'h0001);
                default: load_settings(CFG_W'($urandom),
                                       CFG_W'($urandom),
                                       $urandom_range(0, 2) != 0 ?
                                           16'(int'($urandom_range(0, 720)) - 360) :
                                           CFG_W'($urandom),
                                       CFG_W'($urandom), CFG_W'($urandom),
                                       CFG_W'($urandom));
            endcase
            idle_on = 1'($urandom_range(0, 1));
            send_random(ITEMS_PER_PASS);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
src/otwpc_pkg.sv
src/omni_three_wheel_p_controller_core.sv
test/omni_three_wheel_p_controller_core_tb.sv
